FILE: hdl/ccr_pkg.sv
// Shared types, constants and rounding helpers for the circle collision response block.
// Used by every module in this folder; depends on nothing else.

package ccr_pkg;

	// Fixed-point format and derived constants.
	localparam int FRAC_BITS = 16;
	localparam int KEEP_Q    = ((2 ** FRAC_BITS) * 4 + 2) / 5;
	localparam int DIST_W    = 34;
	localparam int SQ_W      = 66;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NORM_W    = FRAC_BITS + 2;
	localparam int NUM_W     = DIST_W + FRAC_BITS;
	localparam int PROD_W    = 72;

	// Operands of one body-obstacle pair as they travel down the pipeline.
	typedef struct packed {
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] ovx;
		logic signed [31:0] ovy;
		logic [31:0]        target;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic               coin;
	} ccr_item_t;

	// One resolved result.
	typedef struct packed {
		logic               coincident;
		logic               overlapping;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} ccr_res_t;

	// Drop the fraction bits of a product, rounding to nearest with ties away from zero.
	function automatic logic signed [PROD_W-1:0] rshift(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] m;
		m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		m = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[PROD_W-1] ? -signed'(m) : signed'(m);
	endfunction

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		if (v > 72'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

FILE: hdl/ccr_sqrt.sv
// Bit-per-stage pipelined floor square root of the squared center distance.
// Depends on ccr_pkg.

module ccr_sqrt import ccr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_v,
	input  ccr_item_t           in_it,
	input  logic [SQ_W-1:0]     in_sq,
	output logic                out_v,
	output ccr_item_t           out_it,
	output logic [DIST_W-1:0]   out_dist
);

	localparam int STEPS = DIST_W;

	logic              v_s    [STEPS];
	ccr_item_t         it_s   [STEPS];
	logic [DIST_W-1:0] r_s    [STEPS];
	logic [SQ_W-1:0]   rem_s  [STEPS];

	// Each stage decides one result bit, from the most significant down.
	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic              v_in;
		ccr_item_t         it_in;
		logic [DIST_W-1:0] r_in;
		logic [SQ_W-1:0]   rem_in;
		logic [SQ_W+2:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in   = in_v;
			assign it_in  = in_it;
			assign r_in   = '0;
			assign rem_in = in_sq;
		end else begin : g_rest
			assign v_in   = v_s[k-1];
			assign it_in  = it_s[k-1];
			assign r_in   = r_s[k-1];
			assign rem_in = rem_s[k-1];
		end

		// Trial term is 2*r*2^b + 2^(2b) for result bit b.
		assign trial = ((SQ_W+3)'(r_in) << (DIST_W - k))
			| ((SQ_W+3)'(1) << (2 * (DIST_W - 1 - k)));
		assign take  = (SQ_W+3)'(rem_in) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_s[k]  <= it_in;
				r_s[k]   <= take ? (r_in | (DIST_W'(1) << (DIST_W - 1 - k))) : r_in;
				rem_s[k] <= take ? (rem_in - trial[SQ_W-1:0]) : rem_in;
			end
		end
	end

	assign out_v    = v_s[STEPS-1];
	assign out_it   = it_s[STEPS-1];
	assign out_dist = r_s[STEPS-1];

`ifndef SYNTH
	// A floor root leaves a remainder of at most twice the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s[STEPS-1] |-> (SQ_W+1)'(rem_s[STEPS-1]) <= ((SQ_W+1)'(r_s[STEPS-1]) << 1))
		else $error("square root remainder out of range");
`endif

endmodule

FILE: hdl/ccr_div.sv
// Pipelined restoring division that forms the two contact normal components.
// Depends on ccr_pkg.

module ccr_div import ccr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_v,
	input  ccr_item_t                in_it,
	input  logic [DIST_W-1:0]        in_dist,
	output logic                     out_v,
	output ccr_item_t                out_it,
	output logic [DIST_W-1:0]        out_dist,
	output logic signed [NORM_W-1:0] out_nx,
	output logic signed [NORM_W-1:0] out_ny
);

	localparam int STEPS = QUO_W;

	logic              pre_v_s;
	ccr_item_t         pre_it_s;
	logic [DIST_W-1:0] pre_dist_s;
	logic [NUM_W-1:0]  pre_num_s [2];
	logic [32:0]       mag_c     [2];

	logic              v_s    [STEPS];
	ccr_item_t         it_s   [STEPS];
	logic [DIST_W-1:0] dist_s [STEPS];
	logic [NUM_W-1:0]  rem_s  [STEPS][2];
	logic [QUO_W-1:0]  q_s    [STEPS][2];

	// Magnitudes of the offset components.
	always_comb begin
		mag_c[0] = in_it.dx[32] ? 33'(-in_it.dx) : 33'(in_it.dx);
		mag_c[1] = in_it.dy[32] ? 33'(-in_it.dy) : 33'(in_it.dy);
	end

	// Dividend with the half-divisor added for round-half-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_v_s <= 1'b0;
		end else if (adv) begin
			pre_v_s <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_it_s   <= in_it;
			pre_dist_s <= in_dist;
			for (int l = 0; l < 2; l++) begin
				pre_num_s[l] <= (NUM_W'(mag_c[l]) << FRAC_BITS) + NUM_W'(in_dist >> 1);
			end
		end
	end

	// One quotient bit per stage for both lanes.
	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic              v_in;
		ccr_item_t         it_in;
		logic [DIST_W-1:0] dist_in;
		logic [NUM_W-1:0]  rem_in [2];
		logic [QUO_W-1:0]  q_in   [2];
		logic [NUM_W-1:0]  dsh;

		if (k == 0) begin : g_first
			assign v_in    = pre_v_s;
			assign it_in   = pre_it_s;
			assign dist_in = pre_dist_s;
			assign rem_in  = pre_num_s;
			assign q_in[0] = '0;
			assign q_in[1] = '0;
		end else begin : g_rest
			assign v_in    = v_s[k-1];
			assign it_in   = it_s[k-1];
			assign dist_in = dist_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign q_in    = q_s[k-1];
		end

		assign dsh = NUM_W'(dist_in) << (STEPS - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_s[k]   <= it_in;
				dist_s[k] <= dist_in;
				for (int l = 0; l < 2; l++) begin
					if (rem_in[l] >= dsh) begin
						rem_s[k][l] <= rem_in[l] - dsh;
						q_s[k][l]   <= q_in[l] | (QUO_W'(1) << (STEPS - 1 - k));
					end else begin
						rem_s[k][l] <= rem_in[l];
						q_s[k][l]   <= q_in[l];
					end
				end
			end
		end
	end

	// Restore the sign of each offset component.
	assign out_v    = v_s[STEPS-1];
	assign out_it   = it_s[STEPS-1];
	assign out_dist = dist_s[STEPS-1];
	assign out_nx   = out_it.dx[32] ? -signed'({1'b0, q_s[STEPS-1][0]})
		: signed'({1'b0, q_s[STEPS-1][0]});
	assign out_ny   = out_it.dy[32] ? -signed'({1'b0, q_s[STEPS-1][1]})
		: signed'({1'b0, q_s[STEPS-1][1]});

`ifndef SYNTH
	// A unit normal never exceeds one in magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_it.coin |->
			q_s[STEPS-1][0] <= (QUO_W'(1) << FRAC_BITS)
			&& q_s[STEPS-1][1] <= (QUO_W'(1) << FRAC_BITS))
		else $error("normal component above one");
`endif

endmodule

FILE: hdl/ccr_resp.sv
// Response stages: push-out along the normal, velocity correction, damping and saturation.
// Depends on ccr_pkg.

module ccr_resp import ccr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_v,
	input  ccr_item_t                in_it,
	input  logic [DIST_W-1:0]        in_dist,
	input  logic signed [NORM_W-1:0] in_nx,
	input  logic signed [NORM_W-1:0] in_ny,
	output logic                     out_v,
	output ccr_res_t                 out_res
);

	logic                     over_c;
	logic [32:0]              tdiff_c;
	logic signed [32:0]       rx_c;
	logic signed [32:0]       ry_c;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ccr_item_t                it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic                     over_s1, over_s2, over_s3, over_s4, over_s5, over_s6;
	logic signed [NORM_W-1:0] nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic signed [32:0]       rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3, rx_s4, ry_s4;
	logic signed [PROD_W-1:0] prx_s1, pry_s1, pushp_s1;
	logic signed [34:0]       push_s2;
	logic signed [PROD_W-1:0] rnsum_s2;
	logic signed [37:0]       rn_s3;
	logic signed [PROD_W-1:0] pmx_s3, pmy_s3;
	logic signed [34:0]       px_s4, py_s4, px_s5, py_s5, px_s6, py_s6;
	logic signed [PROD_W-1:0] rnx_s4, rny_s4;
	logic                     neg_s4;
	logic signed [37:0]       rx2_s5, ry2_s5;
	logic signed [PROD_W-1:0] kx_s6, ky_s6;
	logic                     v_s7;
	ccr_res_t                 res_s7;

	// Overlap test and relative velocity.
	always_comb begin
		over_c  = !in_it.coin && (DIST_W'(in_it.target) > in_dist);
		tdiff_c = 33'(DIST_W'(in_it.target) - in_dist);
		rx_c    = 33'(in_it.bvx) - 33'(in_it.ovx);
		ry_c    = 33'(in_it.bvy) - 33'(in_it.ovy);
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Datapath stages, one multiply or one add-and-round between registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Normal projection products and the scaled overlap.
			it_s1    <= in_it;
			over_s1  <= over_c;
			nx_s1    <= in_nx;
			ny_s1    <= in_ny;
			rx_s1    <= rx_c;
			ry_s1    <= ry_c;
			prx_s1   <= PROD_W'(rx_c) * PROD_W'(in_nx);
			pry_s1   <= PROD_W'(ry_c) * PROD_W'(in_ny);
			pushp_s1 <= signed'(PROD_W'(tdiff_c)) * PROD_W'(KEEP_Q);

			// Push distance and the summed projection.
			it_s2    <= it_s1;
			over_s2  <= over_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			rx_s2    <= rx_s1;
			ry_s2    <= ry_s1;
			push_s2  <= 35'(rshift(pushp_s1));
			rnsum_s2 <= prx_s1 + pry_s1;

			// Normal relative speed and push vector.
			it_s3   <= it_s2;
			over_s3 <= over_s2;
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			rn_s3   <= 38'(rshift(rnsum_s2));
			pmx_s3  <= PROD_W'(nx_s2) * PROD_W'(push_s2);
			pmy_s3  <= PROD_W'(ny_s2) * PROD_W'(push_s2);

			// Pushed position and the normal velocity part.
			it_s4   <= it_s3;
			over_s4 <= over_s3;
			rx_s4   <= rx_s3;
			ry_s4   <= ry_s3;
			px_s4   <= over_s3 ? 35'(it_s3.bx) + 35'(rshift(pmx_s3)) : 35'(it_s3.bx);
			py_s4   <= over_s3 ? 35'(it_s3.by) + 35'(rshift(pmy_s3)) : 35'(it_s3.by);
			rnx_s4  <= PROD_W'(rn_s3) * PROD_W'(nx_s3);
			rny_s4  <= PROD_W'(rn_s3) * PROD_W'(ny_s3);
			neg_s4  <= rn_s3[37];

			// Remove an approaching normal component.
			it_s5   <= it_s4;
			over_s5 <= over_s4;
			px_s5   <= px_s4;
			py_s5   <= py_s4;
			rx2_s5  <= neg_s4 ? 38'(rx_s4) - 38'(rshift(rnx_s4)) : 38'(rx_s4);
			ry2_s5  <= neg_s4 ? 38'(ry_s4) - 38'(rshift(rny_s4)) : 38'(ry_s4);

			// Damping product.
			it_s6   <= it_s5;
			over_s6 <= over_s5;
			px_s6   <= px_s5;
			py_s6   <= py_s5;
			kx_s6   <= PROD_W'(rx2_s5) * PROD_W'(KEEP_Q);
			ky_s6   <= PROD_W'(ry2_s5) * PROD_W'(KEEP_Q);

			// Output register: saturate, or place the body beside a coincident obstacle.
			if (it_s6.coin) begin
				res_s7.pos_x       <= sat32(PROD_W'(it_s6.ox) + PROD_W'(it_s6.target));
				res_s7.pos_y       <= it_s6.oy;
				res_s7.vel_x       <= it_s6.ovx;
				res_s7.vel_y       <= it_s6.ovy;
				res_s7.overlapping <= it_s6.target != '0;
				res_s7.coincident  <= 1'b1;
			end else begin
				res_s7.pos_x       <= sat32(PROD_W'(px_s6));
				res_s7.pos_y       <= sat32(PROD_W'(py_s6));
				res_s7.vel_x       <= sat32(PROD_W'(it_s6.ovx) + rshift(kx_s6));
				res_s7.vel_y       <= sat32(PROD_W'(it_s6.ovy) + rshift(ky_s6));
				res_s7.overlapping <= over_s6;
				res_s7.coincident  <= 1'b0;
			end
		end
	end

	assign out_v   = v_s7;
	assign out_res = res_s7;

`ifndef SYNTH
	// Coincident centers never reach the overlap-based push.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && it_s1.coin |-> !over_s1)
		else $error("overlap flagged for coincident centers");
`endif

endmodule

FILE: hdl/circle_collision_response_top.sv
// Top level of the circle collision response block: ports, register file and front stages.
// Depends on ccr_pkg, ccr_sqrt, ccr_div and ccr_resp.

// Resolves one moving body against one circle obstacle per transfer, in Q16.16 fixed point.
// The pipeline takes a new item every cycle unless the output is held, and each item passes
// through 3 front stages (offset, squares, sum), 34 square-root stages (one root
// bit each), 1 + 17 division stages (one quotient bit each) and 7 response stages, the
// last being the output register. When the output is held by the downstream side the
// whole pipeline holds with it, and s_tready drops in that cycle. body_radius is at byte
// address 0 and should be written only while no item is in flight.

module circle_collision_response_top import ccr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	// body_pos_x, body_pos_y, body_vel_x, body_vel_y, obstacle_pos_x, obstacle_pos_y,
	// obstacle_vel_x, obstacle_vel_y (32 bits each), obstacle_radius (31), one pad bit
	input  logic [287:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y (32 bits each), overlapping,
	// coincident, six pad bits
	output logic [135:0]  m_tdata
);

	localparam logic [2:0] ADDR_BODY_RADIUS = 3'd0;

	logic [30:0]       body_radius_q;
	logic              adv;
	ccr_item_t         item_c;
	logic [32:0]       ax_c;
	logic [32:0]       ay_c;

	logic              v_s1, v_s2, v_s3;
	ccr_item_t         item_s1, item_s2, item_s3;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sq_s3;

	logic              sq_v;
	ccr_item_t         sq_it;
	logic [DIST_W-1:0] sq_dist;
	logic              dv_v;
	ccr_item_t         dv_it;
	logic [DIST_W-1:0] dv_dist;
	logic signed [NORM_W-1:0] dv_nx, dv_ny;
	ccr_res_t          res;

	// Register file.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BODY_RADIUS) ? {1'b0, body_radius_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_radius_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_BODY_RADIUS) begin
			body_radius_q <= pwdata[30:0];
		end
	end

	// The whole pipeline moves when the output register is free or being drained.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Unpack the input transfer and form the offset and contact distance.
	always_comb begin
		item_c.bx     = s_tdata[31:0];
		item_c.by     = s_tdata[63:32];
		item_c.bvx    = s_tdata[95:64];
		item_c.bvy    = s_tdata[127:96];
		item_c.ox     = s_tdata[159:128];
		item_c.oy     = s_tdata[191:160];
		item_c.ovx    = s_tdata[223:192];
		item_c.ovy    = s_tdata[255:224];
		item_c.target = {1'b0, body_radius_q} + {1'b0, s_tdata[286:256]};
		item_c.dx     = 33'(item_c.bx) - 33'(item_c.ox);
		item_c.dy     = 33'(item_c.by) - 33'(item_c.oy);
		item_c.coin   = (item_c.bx == item_c.ox) && (item_c.by == item_c.oy);
	end

	always_comb begin
		ax_c = item_s1.dx[32] ? 33'(-item_s1.dx) : 33'(item_s1.dx);
		ay_c = item_s1.dy[32] ? 33'(-item_s1.dy) : 33'(item_s1.dy);
	end

	// Front stages: offset, squares, sum of squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_c;
			item_s2 <= item_s1;
			sqx_s2  <= SQ_W'(ax_c) * SQ_W'(ax_c);
			sqy_s2  <= SQ_W'(ay_c) * SQ_W'(ay_c);
			item_s3 <= item_s2;
			sq_s3   <= sqx_s2 + sqy_s2;
		end
	end

	ccr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s3),
		.in_it    (item_s3),
		.in_sq    (sq_s3),
		.out_v    (sq_v),
		.out_it   (sq_it),
		.out_dist (sq_dist)
	);

	ccr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (sq_v),
		.in_it    (sq_it),
		.in_dist  (sq_dist),
		.out_v    (dv_v),
		.out_it   (dv_it),
		.out_dist (dv_dist),
		.out_nx   (dv_nx),
		.out_ny   (dv_ny)
	);

	ccr_resp u_resp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (dv_v),
		.in_it   (dv_it),
		.in_dist (dv_dist),
		.in_nx   (dv_nx),
		.in_ny   (dv_ny),
		.out_v   (m_tvalid),
		.out_res (res)
	);

	assign m_tdata = {6'b0, res.coincident, res.overlapping,
		res.vel_y, res.vel_x, res.pos_y, res.pos_x};

`ifndef SYNTH
	// A held output must block new input.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output is stalled");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for circle_collision_response_top: directed and random body-obstacle
// pairs, a predictor in fixed point, and an in-order result check. Depends on ccr_pkg and the RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ccr_pkg::*;

	localparam int PIPE_LAT = 62;
	localparam logic [2:0] ADDR_BODY_RADIUS = 3'd0;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] bx, by, bvx, bvy, ox, oy, ovx, ovy;
		logic [30:0] orad;
	} pair_t;

	typedef struct {
		logic signed [31:0] px, py, vx, vy;
		logic over, coin;
	} resolved_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// body_pos_x, body_pos_y, body_vel_x, body_vel_y, obstacle_pos_x, obstacle_pos_y,
	// obstacle_vel_x, obstacle_vel_y, obstacle_radius, pad
	logic [287:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, overlapping, coincident, pad
	logic [135:0] m_tdata;

	logic [30:0] body_radius_q = '0;
	resolved_t expected_q[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;

	circle_collision_response_top i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Predictor helpers in wide signed arithmetic.
	function automatic longint mag_of(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint qround(input longint v);
		longint m;
		m = (mag_of(v) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return v < 0 ? -m : m;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unit_comp(input longint d, input longint root);
		logic [127:0] m;
		logic [127:0] q;
		m = 128'(mag_of(d)) << FRAC_BITS;
		q = (m + 128'(root >> 1)) / 128'(root);
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic resolved_t resolve_pair(input pair_t p);
		resolved_t r;
		longint keep, target, dx, dy, root, nx, ny, px, py, rx, ry, rn, push;
		logic [127:0] sq, c;
		keep = ((64'sd1 <<< FRAC_BITS) * 4 + 2) / 5;
		target = longint'(body_radius_q) + longint'(p.orad);
		dx = longint'(p.bx) - longint'(p.ox);
		dy = longint'(p.by) - longint'(p.oy);
		if (dx == 0 && dy == 0) begin
			r.px = clamp32(longint'(p.ox) + target);
			r.py = p.oy;
			r.vx = p.ovx;
			r.vy = p.ovy;
			r.over = target > 0;
			r.coin = 1'b1;
			return r;
		end
		sq = 128'(mag_of(dx)) * 128'(mag_of(dx)) + 128'(mag_of(dy)) * 128'(mag_of(dy));
		root = 0;
		for (int b = 33; b >= 0; b--) begin
			c = 128'(root | (64'sd1 <<< b));
			if (c * c <= sq) root = longint'(c);
		end
		nx = unit_comp(dx, root);
		ny = unit_comp(dy, root);
		px = p.bx;
		py = p.by;
		r.over = root < target;
		if (r.over) begin
			push = qround((target - root) * keep);
			px += qround(nx * push);
			py += qround(ny * push);
		end
		rx = longint'(p.bvx) - longint'(p.ovx);
		ry = longint'(p.bvy) - longint'(p.ovy);
		rn = qround(rx * nx + ry * ny);
		if (rn < 0) begin
			rx -= qround(rn * nx);
			ry -= qround(rn * ny);
		end
		rx = qround(rx * keep);
		ry = qround(ry * keep);
		r.px = clamp32(px);
		r.py = clamp32(py);
		r.vx = clamp32(longint'(p.ovx) + rx);
		r.vy = clamp32(longint'(p.ovy) + ry);
		r.coin = 1'b0;
		return r;
	endfunction

	// Register write over the configuration port, setup then access.
	task automatic write_body_radius(input logic [30:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_BODY_RADIUS;
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		body_radius_q = value;
	endtask

	// One input transfer, with random idle cycles before it. The valid stays high
	// after an accepted transfer so that the next one can follow on the very next edge.
	task automatic send_pair(input pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, p.orad, p.ovy, p.ovx, p.oy, p.ox, p.bvy, p.bvx, p.by, p.bx};
		expected_q.push_back(resolve_pair(p));
		sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// Receiver back-pressure and result check.
	always @(posedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				resolved_t e;
				e = expected_q.pop_front();
				checked++;
				if (m_tdata[31:0] !== e.px) begin
					$error("new_pos_x exp %0d got %0d", e.px, $signed(m_tdata[31:0]));
					errors++;
				end
				if (m_tdata[63:32] !== e.py) begin
					$error("new_pos_y exp %0d got %0d", e.py, $signed(m_tdata[63:32]));
					errors++;
				end
				if (m_tdata[95:64] !== e.vx) begin
					$error("new_vel_x exp %0d got %0d", e.vx, $signed(m_tdata[95:64]));
					errors++;
				end
				if (m_tdata[127:96] !== e.vy) begin
					$error("new_vel_y exp %0d got %0d", e.vy, $signed(m_tdata[127:96]));
					errors++;
				end
				if (m_tdata[128] !== e.over) begin
					$error("overlapping exp %0b got %0b", e.over, m_tdata[128]);
					errors++;
				end
				if (m_tdata[129] !== e.coin) begin
					$error("coincident exp %0b got %0b", e.coin, m_tdata[129]);
					errors++;
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_word();
		return $urandom();
	endfunction

	function automatic logic signed [31:0] rand_near(input int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	// Pairs close together with radii around their distance, so contact is common.
	function automatic pair_t contact_pair();
		pair_t p;
		int span;
		span = 1 << $urandom_range(8, 24);
		p.ox = rand_near(1 << 28);
		p.oy = rand_near(1 << 28);
		p.bx = p.ox + rand_near(span);
		p.by = p.oy + rand_near(span);
		p.bvx = rand_near(1 << $urandom_range(4, 30));
		p.bvy = rand_near(1 << $urandom_range(4, 30));
		p.ovx = rand_near(1 << $urandom_range(4, 30));
		p.ovy = rand_near(1 << $urandom_range(4, 30));
		p.orad = 31'($urandom_range(span));
		return p;
	endfunction

	function automatic pair_t noise_pair();
		pair_t p;
		p.bx = rand_word(); p.by = rand_word(); p.bvx = rand_word(); p.bvy = rand_word();
		p.ox = rand_word(); p.oy = rand_word(); p.ovx = rand_word(); p.ovy = rand_word();
		p.orad = 31'($urandom());
		return p;
	endfunction

	// Extremes, coincident centers, separating and approaching motion, no overlap, random pairs.
	task automatic test_directed();
		pair_t p;
		p = '{0, 0, 0, 0, 0, 0, 0, 0, 31'h0};
		send_pair(p);                                   // coincident, zero obstacle radius
		p.orad = 31'h7fffffff; p.ox = 32'sh7fffffff; p.bx = p.ox;
		send_pair(p);                                   // coincident, saturated placement
		p = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff};
		send_pair(p);                                   // widest offset, saturating outputs
		p = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 31'h0};
		send_pair(p);
		p = '{32'sh10000, 0, -32'sh20000, 0, 0, 0, 0, 0, 31'h20000};
		send_pair(p);                                   // overlap, approaching
		p.bvx = 32'sh20000;
		send_pair(p);                                   // overlap, separating
		p = '{32'sh1000000, 0, -32'sh10000, 32'sh5000, 0, 0, 32'sh100, 0, 31'h10000};
		send_pair(p);                                   // no overlap at zero body radius
		p = '{1, 1, -1, -1, 0, 0, 0, 0, 31'h3};
		send_pair(p);                                   // tiny distance
		p = '{0, -32'sh30000, 0, 32'sh40000, 0, 0, 0, 0, 31'h40000};
		send_pair(p);
		p = '{-5, 0, 0, 0, 0, 0, 0, 0, 31'h7fffffff};
		send_pair(p);
		for (int k = 0; k < 8; k++) send_pair(contact_pair());
		for (int k = 0; k < 4; k++) send_pair(noise_pair());
	endtask

	task automatic test_random(input int count);
		pair_t p;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 7) p = contact_pair();
			else if ($urandom_range(9) == 0) begin
				p = contact_pair();
				p.bx = p.ox;
				p.by = p.oy;
			end else p = noise_pair();
			send_pair(p);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 10;
		recv_idle_pct = 48;
		test_directed();
		drain_results();
		write_body_radius(31'h7fffffff);
		test_directed();
		test_random(200);
		drain_results();
		write_body_radius(31'h18000);
		send_idle_pct = 48;
		recv_idle_pct = 10;
		test_random(400);
		drain_results();
		write_body_radius(31'($urandom()));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(300);
		drain_results();
		write_body_radius(31'h0);
		test_random(300);
		drain_results();
		$display("Covered %0d pairs over five body radius settings, %0d results checked.",
			sent, checked);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
